// File: rtl/aabb_pkg.sv
package aabb_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int IDX_BITS   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic signed [COORD_BITS:0]   t_edge;
    typedef logic        [IDX_BITS-1:0]   t_idx;
    typedef logic        [CNT_BITS-1:0]   t_cnt;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_ADDED     = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_QUERY     = 2'd3
    } t_status;

    typedef struct packed {
        t_command command;
        t_coord   box_x;
        t_coord   box_y;
        t_size    box_w;
        t_size    box_h;
    } t_in_item;

    typedef struct packed {
        t_status status;
        logic    touches_any;
        logic    hit_found;
        t_coord  hit_x;
        t_coord  hit_y;
        t_size   hit_w;
        t_size   hit_h;
        logic    is_over;
        logic    is_left_of;
        logic    is_right_of;
        logic    is_under;
    } t_out_item;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_size  w;
        t_size  h;
    } t_box;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        t_idx rd_idx;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cnt count;
    } t_dp_stat;

    // coordinate widened by one bit
    function automatic t_edge ext_coord(input t_coord c);
        return t_edge'(c);
    endfunction

    // far edge at full precision, never wraps
    function automatic t_edge edge_sum(input t_coord c, input t_size s);
        return t_edge'(c) + t_edge'({2'b00, s});
    endfunction

endpackage

// File: rtl/aabb_ctrl.sv
module aabb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output aabb_pkg::t_dp_cmd  o_cmd,
    input  aabb_pkg::t_dp_stat i_stat
);

    aabb_pkg::t_state r_state, n_state;
    aabb_pkg::t_cnt   r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             scan_done;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_done = (r_idx == i_stat.count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aabb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = aabb_pkg::S_SCAN;
                end
            end
            aabb_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = aabb_pkg::S_FINISH;
                end
            end
            aabb_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = aabb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = aabb_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and counters
    always_comb begin
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            aabb_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                n_idx      = '0;
            end
            aabb_pkg::S_SCAN: begin
                if (!scan_done) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = r_idx[aabb_pkg::IDX_BITS-1:0];
                    n_idx        = r_idx + aabb_pkg::t_cnt'(1);
                end
            end
            aabb_pkg::S_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aabb_pkg::S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/aabb_dp.sv
module aabb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aabb_pkg::t_in_item  i_in_item,
    input  aabb_pkg::t_dp_cmd   i_cmd,
    output aabb_pkg::t_dp_stat  o_stat,
    output aabb_pkg::t_out_item o_out_item
);

    aabb_pkg::t_box      r_table [aabb_pkg::MAX_BOXES];
    aabb_pkg::t_box      r_rd_data;
    logic                r_rd_valid;
    aabb_pkg::t_cnt      r_count;

    aabb_pkg::t_command  r_cmd;
    aabb_pkg::t_box      r_q;
    aabb_pkg::t_edge     r_q_right;
    aabb_pkg::t_edge     r_q_bottom;

    logic                r_dup;
    logic                r_touch;
    logic                r_found;
    aabb_pkg::t_box      r_hit;
    aabb_pkg::t_out_item r_out;

    aabb_pkg::t_edge     b_left, b_top, b_right, b_bottom;
    aabb_pkg::t_edge     q_left, q_top;
    aabb_pkg::t_edge     h_left, h_top, h_right, h_bottom;
    logic                is_touch, is_strict, is_same;
    logic                table_full, do_write;
    aabb_pkg::t_out_item n_out;

    // compare the entry read last cycle against the query
    always_comb begin
        b_left    = aabb_pkg::ext_coord(r_rd_data.x);
        b_top     = aabb_pkg::ext_coord(r_rd_data.y);
        b_right   = aabb_pkg::edge_sum(r_rd_data.x, r_rd_data.w);
        b_bottom  = aabb_pkg::edge_sum(r_rd_data.y, r_rd_data.h);
        q_left    = aabb_pkg::ext_coord(r_q.x);
        q_top     = aabb_pkg::ext_coord(r_q.y);
        is_touch  = !(b_left > r_q_right || b_right < q_left ||
                      b_top > r_q_bottom || b_bottom < q_top);
        is_strict = !(b_left >= r_q_right || b_right <= q_left ||
                      b_top >= r_q_bottom || b_bottom <= q_top);
        is_same   = (r_rd_data == r_q);
    end

    // result of the finished item
    always_comb begin
        h_left     = aabb_pkg::ext_coord(r_hit.x);
        h_top      = aabb_pkg::ext_coord(r_hit.y);
        h_right    = aabb_pkg::edge_sum(r_hit.x, r_hit.w);
        h_bottom   = aabb_pkg::edge_sum(r_hit.y, r_hit.h);
        table_full = (r_count == aabb_pkg::t_cnt'(aabb_pkg::MAX_BOXES));
        do_write   = i_cmd.commit && (r_cmd == aabb_pkg::CMD_ADD) && !r_dup && !table_full;
        n_out      = '0;
        if (r_cmd == aabb_pkg::CMD_ADD) begin
            priority if (r_dup) begin
                n_out.status = aabb_pkg::ST_DUPLICATE;
            end else if (table_full) begin
                n_out.status = aabb_pkg::ST_FULL;
            end else begin
                n_out.status = aabb_pkg::ST_ADDED;
            end
        end else begin
            n_out.status      = aabb_pkg::ST_QUERY;
            n_out.touches_any = r_touch;
            n_out.hit_found   = r_found;
            if (r_found) begin
                n_out.hit_x       = r_hit.x;
                n_out.hit_y       = r_hit.y;
                n_out.hit_w       = r_hit.w;
                n_out.hit_h       = r_hit.h;
                n_out.is_over     = (h_top < r_q_bottom) && (r_q_bottom < h_bottom);
                n_out.is_left_of  = (h_left < q_left) && (q_left < h_right);
                n_out.is_right_of = (h_left < r_q_right) && (r_q_right < h_right);
                n_out.is_under    = (q_top < h_bottom) && (h_bottom < r_q_bottom);
            end
        end
    end

    // box store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_table[r_count[aabb_pkg::IDX_BITS-1:0]] <= r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_table[i_cmd.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_count    <= '0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            if (do_write) begin
                r_count <= r_count + aabb_pkg::t_cnt'(1);
            end
        end
    end

    // query capture and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_in_item.command;
            r_q.x      <= i_in_item.box_x;
            r_q.y      <= i_in_item.box_y;
            r_q.w      <= i_in_item.box_w;
            r_q.h      <= i_in_item.box_h;
            r_q_right  <= aabb_pkg::edge_sum(i_in_item.box_x, i_in_item.box_w);
            r_q_bottom <= aabb_pkg::edge_sum(i_in_item.box_y, i_in_item.box_h);
            r_dup      <= 1'b0;
            r_touch    <= 1'b0;
            r_found    <= 1'b0;
            r_hit      <= '0;
        end else if (r_rd_valid) begin
            if (is_same) begin
                r_dup <= 1'b1;
            end
            if (is_touch) begin
                r_touch <= 1'b1;
            end
            if (is_strict && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.count = r_count;
    assign o_out_item   = r_out;

endmodule

// File: rtl/aabb_box_table_collision_unit.sv
// box table with overlap queries
//
// input channel: i_in_valid / o_in_stall carry one item (command, box).
// an add stores the box unless an identical one is stored or the table
// is full; a query scans the stored boxes in insertion order for the
// touching flag and the first strict hit with its side flags.
// output channel: o_out_valid / i_out_stall carry exactly one result item
// per accepted item, in order.
// the scan reads one table entry per cycle, for each stored box in turn,
// through the single read port of the box store. a new item is taken only
// after the previous one has been written back to the result register.
// the result waits in an output register; the next item is taken and
// scanned while it waits, and only the final write-back holds while the
// receiver stalls with the previous result still unread.
// reset (synchronous, active low) empties the table by clearing the box
// count and drops any pending result; stored entries are not cleared.
module aabb_box_table_collision_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  aabb_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output aabb_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);

    aabb_pkg::t_dp_cmd  cmd;
    aabb_pkg::t_dp_stat stat;

    // sequencer: accept, scan counter, write-back, output valid
    aabb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // box store, compare logic and result register
    aabb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

// File: rtl/aabb_chk.sv
module aabb_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input aabb_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);

    // a pending result is not dropped while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    // one item at a time: after an accept the input side is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after accept");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a strict hit is a query result and also touches
    a_hit_is_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit_found |->
            o_out_item.touches_any && o_out_item.status == aabb_pkg::ST_QUERY)
        else $error("hit reported inconsistently");

    // without a hit all hit fields and side flags are zero
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.hit_found |->
            o_out_item.hit_x == '0 && o_out_item.hit_y == '0 &&
            o_out_item.hit_w == '0 && o_out_item.hit_h == '0 &&
            !o_out_item.is_over && !o_out_item.is_left_of &&
            !o_out_item.is_right_of && !o_out_item.is_under)
        else $error("hit fields set without a hit");

endmodule

bind aabb_box_table_collision_unit aabb_chk u_aabb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
